// ===== rtl/mbt_pkg.sv =====
`default_nettype none

package mbt_pkg;

  localparam int MAX_DIM_DEF      = 64;
  localparam int START_COLUMN_DEF = 1;
  localparam int MAX_POINTS_DEF   = 16384;

  localparam int PT_W    = 6;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_CAP      = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  localparam logic FUNC_WRITE = 1'b0;

  typedef struct packed {
    logic            func;
    logic [PT_W-1:0] pixel_row;
    logic [PT_W-1:0] pixel_col;
    logic            pixel_value;
  } item_t;

  typedef struct packed {
    logic [PT_W-1:0] point_row;
    logic [PT_W-1:0] point_col;
    logic            last_point;
    logic [1:0]      status;
  } point_t;

  typedef struct packed {
    logic in_image;
    logic is_start;
  } nbr_flags_t;

  // clockwise neighbour offsets, direction 0 is up-right
  function automatic logic signed [1:0] dir_drow(input logic [2:0] d);
    logic signed [1:0] v;
    unique case (d)
      3'd0: v = -2'sd1;
      3'd1: v = 2'sd0;
      3'd2: v = 2'sd1;
      3'd3: v = 2'sd1;
      3'd4: v = 2'sd1;
      3'd5: v = 2'sd0;
      3'd6: v = -2'sd1;
      3'd7: v = -2'sd1;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] dir_dcol(input logic [2:0] d);
    logic signed [1:0] v;
    unique case (d)
      3'd0: v = 2'sd1;
      3'd1: v = 2'sd1;
      3'd2: v = 2'sd1;
      3'd3: v = 2'sd0;
      3'd4: v = -2'sd1;
      3'd5: v = -2'sd1;
      3'd6: v = -2'sd1;
      3'd7: v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbt_image_mem.sv =====
`default_nettype none

module mbt_image_mem #(
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  localparam int DEPTH = 1 << AW;

  logic mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mbt_nbr.sv =====
`default_nettype none

module mbt_nbr
  import mbt_pkg::*;
#(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int START_COLUMN = START_COLUMN_DEF,
  localparam int CW   = $clog2(MAX_DIM),
  localparam int DIMW = $clog2(MAX_DIM + 1)
) (
  input  wire logic [CW-1:0]   row,
  input  wire logic [CW-1:0]   col,
  input  wire logic [2:0]      dir,
  input  wire logic [CW-1:0]   start_row,
  input  wire logic [DIMW-1:0] rows_used,
  input  wire logic [DIMW-1:0] cols_used,
  output logic [CW-1:0]        nrow,
  output logic [CW-1:0]        ncol,
  output nbr_flags_t           flags
);

  logic signed [CW+1:0] nr;
  logic signed [CW+1:0] nc;
  logic                 inside_grid;

  always_comb begin
    nr = $signed({2'b00, row}) + (CW+2)'(dir_drow(dir));
    nc = $signed({2'b00, col}) + (CW+2)'(dir_dcol(dir));
    // top bit set means the step went off the low edge
    inside_grid = !nr[CW+1] && !nc[CW+1];
    flags.in_image = inside_grid
                     && (nr[CW:0] < (CW+1)'(rows_used))
                     && (nc[CW:0] < (CW+1)'(cols_used));
    flags.is_start = inside_grid
                     && (nr[CW:0] == {1'b0, start_row})
                     && (32'(nc[CW:0]) == START_COLUMN);
    nrow = nr[CW-1:0];
    ncol = nc[CW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/moore_boundary_tracer_unit.sv =====
`default_nettype none

// channel  | signals                            | direction | beat
// ---------+------------------------------------+-----------+------------------------------
// item     | item_valid, item_stall, item       | in        | pixel write or point request
// point    | point_valid, point_stall, point    | out       | one per point request
// cfg      | cfg_valid, cfg_ready, cfg_index,   | in        | image_rows (0), image_cols (1)
//          | cfg_data                           |           |
//
// a point request walks clockwise through up to eight neighbours over the single image
// memory read port
// the first request of a trace first walks the start column, one row read at a time
// after reset a clearing pass zeroes every address of the image memory, with item_stall
// high and cfg_ready low
// cfg beats are taken only while idle and hold item_stall high in that cycle
// a finished point waits in the output register while the next beat comes in

module moore_boundary_tracer_unit
  import mbt_pkg::*;
#(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int START_COLUMN = START_COLUMN_DEF,
  parameter int MAX_POINTS   = MAX_POINTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      point_valid,
  input  wire logic                 point_stall,
  output point_t                    point,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int AW   = 2 * CW;
  localparam int PW   = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FIND  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRACE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  state_t state;
  phase_t phase;

  // configuration
  logic [CFG_W-1:0] image_rows;
  logic [CFG_W-1:0] image_cols;
  logic [DIMW-1:0]  rows_used;
  logic [DIMW-1:0]  cols_used;

  // trace state
  logic [CW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [CW-1:0] start_row;
  logic [2:0]    bd;
  logic [2:0]    next_dir;
  logic [PW-1:0] points;

  // walk bookkeeping: one read in flight, checked the cycle after it issues
  logic [AW-1:0]   clr_addr;
  logic [DIMW-1:0] find_row;
  logic [CW-1:0]   prev_row;
  logic [3:0]      k;
  logic            pv;
  logic [2:0]      prev_dir;
  logic            prev_in;
  point_t          res;

  // shared neighbour unit and memory
  logic [2:0]    dir_sel;
  logic [CW-1:0] nrow;
  logic [CW-1:0] ncol;
  nbr_flags_t    flags;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;

  logic accept;
  logic pix_in_range;

  always_comb begin
    rows_used = (32'(image_rows) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(image_rows);
    cols_used = (32'(image_cols) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(image_cols);
  end

  // a register write takes the idle cycle, the item beat waits
  assign item_stall = (state != S_IDLE) || cfg_valid;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = (state == S_IDLE);

  assign pix_in_range = (32'(item.pixel_row) < MAX_DIM) && (32'(item.pixel_col) < MAX_DIM);

  // in a walk the candidates run clockwise from the one after the backtrack cell; when idle the
  // unit steps the current point along the direction found by the last walk
  assign dir_sel = (state == S_SCAN) ? (bd + 3'd1 + k[2:0]) : next_dir;

  mbt_nbr #(
    .MAX_DIM      (MAX_DIM),
    .START_COLUMN (START_COLUMN)
  ) u_nbr (
    .row       (cur_row),
    .col       (cur_col),
    .dir       (dir_sel),
    .start_row (start_row),
    .rows_used (rows_used),
    .cols_used (cols_used),
    .nrow      (nrow),
    .ncol      (ncol),
    .flags     (flags)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && (item.func == FUNC_WRITE) && pix_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = {CW'(item.pixel_row), CW'(item.pixel_col)};
      mem_wdata = item.pixel_value;
    end
  end

  assign mem_raddr = (state == S_FIND) ? {find_row[CW-1:0], CW'(START_COLUMN)} : {nrow, ncol};

  mbt_image_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      phase       <= PH_IDLE;
      clr_addr    <= '0;
      points      <= '0;
      point_valid <= 1'b0;
      image_rows  <= DIM_RESET;
      image_cols  <= DIM_RESET;
      pv          <= 1'b0;
    end else begin
      // a new beat from S_EMIT replaces the one taken in the same cycle
      if (point_valid && !point_stall && (state != S_EMIT)) begin
        point_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            // register writes also restart the trace
            unique case (cfg_index)
              CFG_ROWS: image_rows <= cfg_data;
              CFG_COLS: image_cols <= cfg_data;
              default:  image_cols <= image_cols;
            endcase
            phase  <= PH_IDLE;
            points <= '0;
          end else if (accept) begin
            if (item.func == FUNC_WRITE) begin
              // any pixel write restarts the trace
              phase  <= PH_IDLE;
              points <= '0;
            end else begin
              unique case (phase)
                PH_TRACE: begin
                  if (32'(points) >= MAX_POINTS) begin
                    phase <= PH_DONE;
                    res   <= '{point_row: '0, point_col: '0, last_point: 1'b0,
                               status: ST_CAP};
                    state <= S_EMIT;
                  end else begin
                    // step to the neighbour found by the look-ahead walk
                    cur_row <= nrow;
                    cur_col <= ncol;
                    bd      <= next_dir + 3'd4;
                    points  <= points + PW'(1);
                    k       <= '0;
                    pv      <= 1'b0;
                    state   <= S_SCAN;
                  end
                end
                PH_IDLE: begin
                  if (32'(START_COLUMN) >= 32'(cols_used)) begin
                    phase <= PH_DONE;
                    res   <= '{point_row: '0, point_col: '0, last_point: 1'b0,
                               status: ST_NO_START};
                    state <= S_EMIT;
                  end else begin
                    find_row <= '0;
                    pv       <= 1'b0;
                    state    <= S_FIND;
                  end
                end
                default: begin
                  res   <= '{point_row: '0, point_col: '0, last_point: 1'b0,
                             status: ST_DONE};
                  state <= S_EMIT;
                end
              endcase
            end
          end
        end

        S_FIND: begin
          if (pv && mem_rdata) begin
            // lowest foreground row of the start column, backtrack cell above
            start_row <= prev_row;
            cur_row   <= prev_row;
            cur_col   <= CW'(START_COLUMN);
            bd        <= 3'd7;
            points    <= PW'(1);
            k         <= '0;
            pv        <= 1'b0;
            state     <= S_SCAN;
          end else if (find_row >= rows_used) begin
            phase <= PH_DONE;
            res   <= '{point_row: '0, point_col: '0, last_point: 1'b0,
                       status: ST_NO_START};
            state <= S_EMIT;
          end else begin
            pv       <= 1'b1;
            prev_row <= find_row[CW-1:0];
            find_row <= find_row + DIMW'(1);
          end
        end

        S_SCAN: begin
          // earlier candidate wins over the start check of the next one
          if (pv && prev_in && mem_rdata) begin
            next_dir <= prev_dir;
            phase    <= PH_TRACE;
            res      <= '{point_row: PT_W'(cur_row), point_col: PT_W'(cur_col),
                          last_point: 1'b0, status: ST_OK};
            state    <= S_EMIT;
          end else if ((k == 4'd8) || flags.is_start) begin
            // back at the start, or all eight around are background
            phase <= PH_DONE;
            res   <= '{point_row: PT_W'(cur_row), point_col: PT_W'(cur_col),
                       last_point: 1'b1, status: ST_OK};
            state <= S_EMIT;
          end else begin
            pv       <= 1'b1;
            prev_dir <= dir_sel;
            prev_in  <= flags.in_image;
            k        <= k + 4'd1;
          end
        end

        S_EMIT: begin
          if (!point_valid || !point_stall) begin
            point       <= res;
            point_valid <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/boundary_trace_checker.sv =====
`default_nettype none

module boundary_trace_checker
  import mbt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire logic                 item_stall,
  input  wire item_t                item,
  input  wire logic                 point_valid,
  input  wire logic                 point_stall,
  input  wire point_t               point,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM       = MAX_DIM_DEF;
  localparam int START_COL = START_COLUMN_DEF;
  localparam int POINT_CAP = MAX_POINTS_DEF;

  typedef enum logic [1:0] {TRACE_IDLE, TRACE_RUN, TRACE_OVER} trace_state_t;

  bit           image [DIM*DIM];
  int unsigned  rows_reg;
  int unsigned  cols_reg;
  int           cur_r;
  int           cur_c;
  int           back_dir;
  int           start_r;
  trace_state_t trace_state;
  int unsigned  steps_taken;
  point_t       expected_points [$];

  function automatic int row_step(input int d);
    case (d)
      1, 5:    return 0;
      2, 3, 4: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic int col_step(input int d);
    case (d)
      0, 1, 2: return 1;
      3, 7:    return 0;
      default: return -1;
    endcase
  endfunction

  // anything outside the rows and columns in use is background
  function automatic bit lit(input int r, input int c);
    int rl;
    int cl;
    rl = (rows_reg > DIM) ? DIM : rows_reg;
    cl = (cols_reg > DIM) ? DIM : cols_reg;
    if (r < 0 || c < 0 || r >= rl || c >= cl) return 1'b0;
    return image[r*DIM + c];
  endfunction

  // clockwise walk after the backtrack cell, -1 on reaching the start or a lone pixel
  function automatic int scan_clockwise(input int r, input int c, input int bd);
    int d;
    int nr;
    int nc;
    for (int k = 0; k < 8; k++) begin
      d  = (bd + 1 + k) % 8;
      nr = r + row_step(d);
      nc = c + col_step(d);
      if (nr == start_r && nc == START_COL) return -1;
      if (lit(nr, nc)) return d;
    end
    return -1;
  endfunction

  function automatic point_t trace_step();
    point_t p;
    int     d;
    int     found;
    p     = '0;
    found = -1;
    case (trace_state)
      TRACE_IDLE: begin
        for (int r = 0; r < DIM; r++)
          if (found < 0 && lit(r, START_COL)) found = r;
        if (found < 0) begin
          trace_state = TRACE_OVER;
          p.status    = ST_NO_START;
          return p;
        end
        start_r     = found;
        cur_r       = found;
        cur_c       = START_COL;
        back_dir    = 7;
        steps_taken = 1;
      end
      TRACE_RUN: begin
        if (steps_taken >= POINT_CAP) begin
          trace_state = TRACE_OVER;
          p.status    = ST_CAP;
          return p;
        end
        d = scan_clockwise(cur_r, cur_c, back_dir);
        if (d < 0) begin
          trace_state = TRACE_OVER;
          p.status    = ST_DONE;
          return p;
        end
        cur_r       = cur_r + row_step(d);
        cur_c       = cur_c + col_step(d);
        back_dir    = (d + 4) % 8;
        steps_taken = steps_taken + 1;
      end
      default: begin
        p.status = ST_DONE;
        return p;
      end
    endcase
    // look ahead so the final point carries last_point
    p.last_point = (scan_clockwise(cur_r, cur_c, back_dir) < 0);
    trace_state  = p.last_point ? TRACE_OVER : TRACE_RUN;
    p.point_row  = PT_W'(cur_r);
    p.point_col  = PT_W'(cur_c);
    p.status     = ST_OK;
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_point(input point_t got);
    point_t want;
    if (expected_points.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing outstanding: row %0d col %0d st %0d",
                                got.point_row, got.point_col, got.status));
      return;
    end
    want = expected_points.pop_front();
    if (got.point_row !== want.point_row)
      report_mismatch($sformatf("point_row got %0d want %0d", got.point_row, want.point_row));
    if (got.point_col !== want.point_col)
      report_mismatch($sformatf("point_col got %0d want %0d", got.point_col, want.point_col));
    if (got.last_point !== want.last_point)
      report_mismatch($sformatf("last_point got %0b want %0b", got.last_point, want.last_point));
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (image[i]) image[i] = 1'b0;
      rows_reg    = DIM_RESET;
      cols_reg    = DIM_RESET;
      cur_r       = 0;
      cur_c       = 0;
      back_dir    = 0;
      start_r     = 0;
      trace_state = TRACE_IDLE;
      steps_taken = 0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROWS) rows_reg = cfg_data;
        else cols_reg = cfg_data;
        trace_state = TRACE_IDLE;
        steps_taken = 0;
      end
      if (item_valid && !item_stall) begin
        if (item.func == FUNC_WRITE) begin
          image[item.pixel_row*DIM + item.pixel_col] = item.pixel_value;
          trace_state = TRACE_IDLE;
          steps_taken = 0;
        end else begin
          expected_points.insert(expected_points.size(), trace_step());
        end
      end
      if (point_valid && !point_stall) check_point(point);
    end
    expected_left <= expected_points.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbt_pkg::*;

  localparam logic FUNC_POINT = ~FUNC_WRITE;
  // quiet cycles allowed: covers the image clearing pass after reset
  localparam int   QUIET_LIMIT = 20000;
  localparam int   ITEM_GOAL   = 800;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 item_valid  = 1'b0;
  item_t                item        = '0;
  logic                 point_stall = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_ROWS;
  logic [CFG_W-1:0]     cfg_data    = DIM_RESET;
  logic                 item_stall;
  logic                 point_valid;
  point_t               point;
  logic                 cfg_ready;

  int          fail_count;
  int          expected_left;
  int          items_sent = 0;
  int          ends_seen  = 0;
  int          quiet      = 0;
  int          stall_left = 0;
  int unsigned cyc        = 0;
  int unsigned roll;
  int unsigned stall_roll;
  bit          burst      = 1'b1;
  int          cur_rows   = 64;
  int          cur_cols   = 64;

  initial begin
    forever #5 clk = ~clk;
  end

  moore_boundary_tracer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point      (point),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  boundary_trace_checker trace_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  // count beats that close a trace, so the sender knows when to move on
  always @(posedge clk) begin
    if (!rst && point_valid && !point_stall && (point.last_point || point.status != ST_OK))
      ends_seen <= ends_seen + 1;
  end

  // receiver stalls: mostly short, a few long, and calm windows set by bits 9:8 of the cycle count
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      point_stall <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      point_stall <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (cyc[9:8] == 2'd1 || stall_roll < 60) begin
        point_stall <= 1'b0;
      end else begin
        point_stall <= 1'b1;
        stall_left  <= (stall_roll < 94) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // watchdog: too long without any beat on any channel means a hang
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (point_valid && !point_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("** moore_boundary_tracer_unit: FAILED **");
        $finish;
      end
    end
  end

  // present one beat and hold it until taken
  task automatic send(input item_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic put(input int r, input int c, input bit v);
    item_t it;
    it             = '0;
    it.func        = FUNC_WRITE;
    it.pixel_row   = PT_W'(r);
    it.pixel_col   = PT_W'(c);
    it.pixel_value = v;
    send(it);
  endtask

  // point request, the pixel fields carry junk the block must ignore
  task automatic ask();
    item_t it;
    it             = '0;
    it.func        = FUNC_POINT;
    it.pixel_row   = PT_W'($urandom);
    it.pixel_col   = PT_W'($urandom);
    it.pixel_value = 1'($urandom);
    send(it);
  endtask

  task automatic idle_gap();
    int n;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) n = 0;
    else if (roll < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every outstanding point beat has come back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  // idle block for register writes: drained plus margin for a pixel write still in flight
  task automatic settle();
    drain();
    repeat (16) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ROWS) cur_rows = val;
    else cur_cols = val;
  endtask

  // request points until the trace closes or the budget runs out
  task automatic trace(input int most);
    int mark;
    int n;
    drain();
    mark = ends_seen;
    n    = 0;
    while (ends_seen == mark && n < most) begin
      ask();
      idle_gap();
      n++;
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  task automatic pick_dims();
    int rows;
    int cols;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      rows = $urandom_range(2, 12);
      cols = $urandom_range(3, 12);
    end else if (roll == 7) begin
      // register extremes, including values past the image size
      case ($urandom_range(0, 3))
        0: rows = 0;
        1: rows = 1;
        2: rows = 64;
        default: rows = 127;
      endcase
      case ($urandom_range(0, 4))
        0: cols = 0;
        1: cols = 1;
        2: cols = 2;
        3: cols = 64;
        default: cols = 127;
      endcase
    end else begin
      rows = $urandom_range(1, 64);
      cols = $urandom_range(2, 64);
    end
    settle();
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 0) set_reg(CFG_ROWS, rows);
      else set_reg(CFG_COLS, cols);
    end else begin
      set_reg(CFG_ROWS, rows);
      set_reg(CFG_COLS, cols);
    end
  endtask

  initial begin
    int  rl;
    int  cl;
    int  nw;
    bit  first;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty image: no start pixel, then the trace stays finished
    ask();
    ask();
    // lone pixel on the top edge, neighbours above read as background
    put(0, 1, 1);
    ask();
    ask();
    // two pixel boundary, start then its right neighbour, then finished
    put(0, 2, 1);
    ask();
    ask();
    ask();
    // field extremes and a lone start on the bottom row
    put(63, 63, 1);
    put(0, 1, 0);
    put(0, 2, 0);
    put(63, 1, 1);
    ask();
    // start column outside the columns in use
    settle();
    set_reg(CFG_COLS, 1);
    ask();
    // oversized register values act as the full image
    settle();
    set_reg(CFG_ROWS, 127);
    set_reg(CFG_COLS, 127);
    ask();
    ask();
    // start pixel sits in a row no longer in use
    settle();
    set_reg(CFG_ROWS, 63);
    ask();

    // random phases: a batch of pixel writes, then a trace walked to its end or cut short
    first = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      if (first || $urandom_range(0, 2) == 0) pick_dims();
      first = 1'b0;
      rl    = (cur_rows > 64) ? 64 : ((cur_rows < 1) ? 1 : cur_rows);
      cl    = (cur_cols > 64) ? 64 : ((cur_cols < 2) ? 2 : cur_cols);
      burst = ($urandom_range(0, 4) == 0);
      nw    = $urandom_range(2, 12);
      repeat (nw) begin
        if ($urandom_range(0, 99) < 85)
          put($urandom_range(0, rl - 1), $urandom_range(0, cl - 1), $urandom_range(0, 99) < 65);
        else
          put($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
        idle_gap();
      end
      // some traces are cut short by the next write
      if ($urandom_range(0, 4) == 0) trace($urandom_range(1, 4));
      else trace(200);
    end

    drain();
    repeat (32) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("** moore_boundary_tracer_unit: PASSED **");
    end else begin
      $display("** moore_boundary_tracer_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== moore_boundary_tracer_unit.f =====
rtl/mbt_pkg.sv
rtl/mbt_image_mem.sv
rtl/mbt_nbr.sv
rtl/moore_boundary_tracer_unit.sv
dv/boundary_trace_checker.sv
dv/tb.sv
